// ----- src/adcss_pkg.sv -----
// ----------------------------------------------------------------------------
// ADC scan sequencer package
// Shared types, register indexes and the channel mapping function of the
// round-robin converter scan sequencer.
// ----------------------------------------------------------------------------
package adcss_pkg;

    // Fixed field widths.
    localparam int unsigned IdxW        = 3;
    localparam int unsigned CountW      = 4;
    localparam int unsigned ConvW       = 10;
    localparam int unsigned SampleW     = 8;
    localparam int unsigned MaxChannelsDefault = 8;

    // Configuration register indexes, taken from paddr[2].
    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam logic REG_REFERENCE     = 1'b1;

    typedef enum logic [1:0] {
        PH_SELECT  = 2'd0,
        PH_ACQUIRE = 2'd1,
        PH_START   = 2'd2,
        PH_WAIT    = 2'd3
    } phase_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              converter_busy;
        logic [ConvW-1:0]  conversion_result;
        logic [IdxW-1:0]   read_index;
    } item_t;

    typedef struct packed {
        logic               select_write;
        logic [IdxW-1:0]    physical_channel;
        logic               start_pulse;
        logic               sample_captured;
        logic [IdxW-1:0]    captured_index;
        logic [SampleW-1:0] read_value;
    } result_t;

    typedef struct packed {
        logic [CountW-1:0] channel_count;
        logic              reference_in_use;
    } cfg_t;

    // Logical to physical channel number. With a reference in use the
    // reference pins are skipped; the sum wraps in three bits.
    function automatic logic [IdxW-1:0] map_channel(
        input logic [IdxW-1:0]   idx,
        input logic [CountW-1:0] count,
        input logic              ref_in_use
    );
        logic [IdxW-1:0] phys;
        phys = idx;
        if (ref_in_use) begin
            case (count)
                4'd3, 4'd4, 4'd6: begin
                    if (idx > 3'd2) begin
                        phys = idx + 3'd2;
                    end
                end
                4'd5, 4'd7: begin
                    if (idx > 3'd3) begin
                        phys = idx + 3'd1;
                    end
                end
                default: begin
                    phys = idx;
                end
            endcase
        end
        return phys;
    endfunction

endpackage

// ----- src/adc_channel_scan_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// ADC channel scan sequencer unit
// Round-robin converter scan sequencer with a stream request channel, a
// stream result channel and an APB-style configuration port.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle and returns exactly one result
// for each, through the input register and then the result register, with
// only the phase machine, channel mapping and sample store lookup between.
// The input register refills while the result register is free or being
// emptied, so one new request is still taken while an earlier result waits on
// the master side; throughput drops below one per cycle only while m_tready
// is held low. A tick request moves the sequencer through channel select,
// acquisition, conversion start and converter wait; in the wait phase it
// stores bits 9..2 of the conversion result for the current channel once the
// converter reports not busy. A read request returns one stored sample and
// changes nothing. The sample store is a small flip-flop array that reset
// clears at once, so the unit is ready once reset is released. Write
// configuration only while no request is in flight; the unit does not enforce it.
module adc_channel_scan_sequencer_unit #(
    parameter int unsigned MAX_CHANNELS = adcss_pkg::MaxChannelsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] converter_busy, [10:1] conversion_result, [13:11] read_index,
    // [15:14] zero
    input  logic [15:0] s_tdata,
    // [0] op
    input  logic [0:0]  s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] select_write, [3:1] physical_channel, [4] start_pulse,
    // [5] sample_captured, [8:6] captured_index, [16:9] read_value,
    // [23:17] zero
    output logic [23:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import adcss_pkg::*;

    // Configuration registers.
    cfg_t     cfg_reg;
    logic     cfg_write;

    // Input register.
    logic     in_valid_reg;
    item_t    in_item_reg;

    // Result register.
    logic     out_valid_reg;
    result_t  out_result_reg;

    logic     advance;
    result_t  seq_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_count    <= CountW'(1);
            cfg_reg.reference_in_use <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_CHANNEL_COUNT: cfg_reg.channel_count    <= pwdata[CountW-1:0];
                REG_REFERENCE:     cfg_reg.reference_in_use <= pwdata[0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_CHANNEL_COUNT: prdata = {{(32-CountW){1'b0}}, cfg_reg.channel_count};
            REG_REFERENCE:     prdata = {31'b0, cfg_reg.reference_in_use};
            default: begin
                prdata = '0;
            end
        endcase
    end

    // The held request moves on whenever the result register is free or
    // is being emptied in this cycle; the input register refills in the
    // same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op                <= op_t'(s_tuser[0]);
            in_item_reg.converter_busy    <= s_tdata[0];
            in_item_reg.conversion_result <= s_tdata[10:1];
            in_item_reg.read_index        <= s_tdata[13:11];
        end
    end

    adcss_seq #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (seq_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= seq_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0,
                       out_result_reg.read_value,
                       out_result_reg.captured_index,
                       out_result_reg.sample_captured,
                       out_result_reg.start_pulse,
                       out_result_reg.physical_channel,
                       out_result_reg.select_write};

endmodule

// ----- src/adcss_seq.sv -----
// ----------------------------------------------------------------------------
// ADC scan sequencer core
// Phase machine, channel index, sample store and the result logic for one
// request per cycle, advancing its state only while step is high.
// ----------------------------------------------------------------------------
module adcss_seq #(
    parameter int unsigned MAX_CHANNELS = adcss_pkg::MaxChannelsDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  adcss_pkg::item_t  item,
    input  adcss_pkg::cfg_t   cfg,
    output adcss_pkg::result_t result
);
    import adcss_pkg::*;

    localparam int unsigned AddrW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [CountW-1:0] MaxCount = CountW'(MAX_CHANNELS);

    phase_t              phase_reg, phase_next;
    logic [IdxW-1:0]     index_reg, index_next;
    logic [SampleW-1:0]  store_reg [MAX_CHANNELS];
    logic                store_we;
    logic [CountW-1:0]   index_inc;
    logic                read_in_range;
    logic                cap_in_range;

    assign index_inc     = {1'b0, index_reg} + CountW'(1);
    assign read_in_range = ({1'b0, item.read_index} < MaxCount);
    assign cap_in_range  = ({1'b0, index_reg} < MaxCount);

    always_comb begin
        phase_next = phase_reg;
        index_next = index_reg;
        store_we   = 1'b0;
        result     = '0;
        if (item.op == OP_READ) begin
            if (read_in_range) begin
                result.read_value = store_reg[item.read_index[AddrW-1:0]];
            end
        end else begin
            case (phase_reg)
                PH_SELECT: begin
                    result.select_write     = 1'b1;
                    result.physical_channel = map_channel(index_reg, cfg.channel_count,
                                                          cfg.reference_in_use);
                    phase_next = PH_ACQUIRE;
                end
                PH_ACQUIRE: begin
                    phase_next = PH_START;
                end
                PH_START: begin
                    result.start_pulse = 1'b1;
                    phase_next = PH_WAIT;
                end
                PH_WAIT: begin
                    if (!item.converter_busy) begin
                        phase_next             = PH_SELECT;
                        result.sample_captured = 1'b1;
                        result.captured_index  = index_reg;
                        store_we               = cap_in_range;
                        if (index_inc == cfg.channel_count || index_inc >= MaxCount) begin
                            index_next = '0;
                        end else begin
                            index_next = index_inc[IdxW-1:0];
                        end
                    end
                end
                default: begin
                    phase_next = PH_SELECT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SELECT;
            index_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
                store_reg[i] <= '0;
            end
        end else if (step && store_we) begin
            store_reg[index_reg[AddrW-1:0]] <= item.conversion_result[ConvW-1:2];
        end
    end

    // A start pulse always leads into the wait phase.
    a_start_to_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.start_pulse |=> phase_reg == PH_WAIT)
        else $error("start pulse did not lead into the wait phase");

    // Read requests leave the sequencer state untouched.
    a_read_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.op == OP_READ |=> $stable(phase_reg) && $stable(index_reg))
        else $error("read request changed sequencer state");

    // The channel index never leaves the store range.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, index_reg} < MaxCount)
        else $error("channel index beyond the channel range");

    // At most one sequencer event per request.
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({result.select_write, result.start_pulse, result.sample_captured}))
        else $error("more than one sequencer event in one request");

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Scan sequencer testbench
// Drives tick and read requests into the round-robin converter scan
// sequencer under random flow control on both stream channels, tracks the
// phase machine, scan index and sample store in a scoreboard, and checks
// every result field against the scoreboard's prediction. The run passes
// through a series of channel count and reference settings, written over
// the APB-style port while the unit is idle.
// ----------------------------------------------------------------------------
module tb;
    import adcss_pkg::*;

    // The scoreboard keeps its own copy of the sequencer state. Each accepted
    // request is turned into the result the unit must return for it, and
    // results are checked strictly in order, since the unit returns exactly
    // one result per request.
    class scan_scoreboard;
        logic [CountW-1:0]  channel_count;
        logic               ref_pins_skipped;
        phase_t             phase;
        logic [IdxW-1:0]    scan_index;
        logic [SampleW-1:0] samples [8];
        result_t            expected_results [$];
        int unsigned        errors;

        function new();
            channel_count    = 4'd1;
            ref_pins_skipped = 1'b0;
            phase            = PH_SELECT;
            scan_index       = '0;
            foreach (samples[i]) begin
                samples[i] = '0;
            end
            errors = 0;
        endfunction

        function void write_register(logic reg_sel, logic [31:0] value);
            if (reg_sel == REG_CHANNEL_COUNT) begin
                channel_count = value[CountW-1:0];
            end else begin
                ref_pins_skipped = value[0];
            end
        endfunction

        // Works out the result of one accepted request and advances the state.
        function void note_request(item_t req);
            result_t           want;
            logic [CountW-1:0] next_index;
            want = '0;
            if (req.op == OP_READ) begin
                want.read_value = samples[req.read_index];
            end else begin
                case (phase)
                    PH_SELECT: begin
                        want.select_write     = 1'b1;
                        want.physical_channel = scan_index;
                        // Reference pins are skipped; the 3-bit sum wraps.
                        if (ref_pins_skipped) begin
                            case (channel_count)
                                4'd3, 4'd4, 4'd6: begin
                                    if (scan_index > 3'd2) begin
                                        want.physical_channel = scan_index + 3'd2;
                                    end
                                end
                                4'd5, 4'd7: begin
                                    if (scan_index > 3'd3) begin
                                        want.physical_channel = scan_index + 3'd1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        phase = PH_ACQUIRE;
                    end
                    PH_ACQUIRE: begin
                        phase = PH_START;
                    end
                    PH_START: begin
                        want.start_pulse = 1'b1;
                        phase = PH_WAIT;
                    end
                    default: begin
                        if (!req.converter_busy) begin
                            want.sample_captured = 1'b1;
                            want.captured_index  = scan_index;
                            samples[scan_index]  = req.conversion_result[9:2];
                            // The index wraps when it meets the count or the
                            // end of the store, whichever comes first.
                            next_index = {1'b0, scan_index} + 4'd1;
                            if (next_index == channel_count || next_index >= 4'd8) begin
                                next_index = '0;
                            end
                            scan_index = next_index[IdxW-1:0];
                            phase = PH_SELECT;
                        end
                    end
                endcase
            end
            expected_results.push_back(want);
        endfunction

        function void check_result(logic [23:0] data);
            result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("result %h arrived with no request outstanding", data);
                end
                return;
            end
            want = expected_results.pop_front();
            if (data[0] !== want.select_write || data[3:1] !== want.physical_channel ||
                    data[4] !== want.start_pulse || data[5] !== want.sample_captured ||
                    data[8:6] !== want.captured_index || data[16:9] !== want.read_value ||
                    data[23:17] !== 7'd0) begin
                errors++;
                if (errors <= 10) begin
                    $display({"mismatch: expected sel=%0d phys=%0d start=%0d cap=%0d",
                              " idx=%0d val=%h pad=0"},
                        want.select_write, want.physical_channel, want.start_pulse,
                        want.sample_captured, want.captured_index, want.read_value);
                    $display({"          actual   sel=%0d phys=%0d start=%0d cap=%0d",
                              " idx=%0d val=%h pad=%h"},
                        data[0], data[3:1], data[4], data[5], data[8:6], data[16:9],
                        data[23:17]);
                end
            end
        endfunction
    endclass

    // One setting of the configuration registers and what the run does in it.
    typedef struct {
        int unsigned count;
        bit          ref_on;
        int unsigned items;
        int          land;       // scan index to reach before leaving, or -1
        bit          quiet;      // no idling on either side
        bit          drain_mid;  // hold requests halfway until all results are back
    } setting_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    bit             calm = 1'b0;
    scan_scoreboard sb;
    setting_t       plan [12];

    adc_channel_scan_sequencer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard limit on the whole run, far above the slowest correct run.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // The result side stalls in about a third of the cycles, except while
    // the quiet stretch is running.
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 32);
    end

    // Every accepted result is checked at the edge that takes it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    function automatic item_t tick_request(logic busy, logic [ConvW-1:0] conv);
        item_t req;
        req = '0;
        req.op                = OP_TICK;
        req.converter_busy    = busy;
        req.conversion_result = conv;
        return req;
    endfunction

    function automatic item_t read_request(logic [IdxW-1:0] idx);
        item_t req;
        req = '0;
        req.op         = OP_READ;
        req.read_index = idx;
        return req;
    endfunction

    // Presents one request, with random idle cycles first, and returns at the
    // falling edge after it is taken. s_tvalid is left high so that
    // back-to-back requests need only one assignment per edge.
    task automatic send_request(input item_t req);
        while (!calm && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, req.read_index, req.conversion_result, req.converter_busy};
        s_tuser  <= req.op;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_request(req);
        @(negedge aclk);
    endtask

    // Holds off requests until every expected result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) begin
            @(negedge aclk);
        end
        @(negedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where pready is seen with the access phase.
    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        sb.write_register(reg_sel, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        item_t req;
        sb = new();

        // Settings visited in order. The count 8 phases end at a chosen scan
        // index so that the following, lower count meets an index beyond it,
        // which also pushes the mapped channel past 7 with a reference in use.
        plan[0]  = '{8,  1'b1, 40, 6,  1'b0, 1'b0};
        plan[1]  = '{6,  1'b1, 40, -1, 1'b0, 1'b0};
        plan[2]  = '{3,  1'b1, 40, -1, 1'b0, 1'b0};
        plan[3]  = '{4,  1'b1, 40, -1, 1'b0, 1'b1};
        plan[4]  = '{5,  1'b1, 40, -1, 1'b1, 1'b0};
        plan[5]  = '{7,  1'b1, 40, -1, 1'b1, 1'b0};
        plan[6]  = '{8,  1'b0, 36, 7,  1'b0, 1'b0};
        plan[7]  = '{3,  1'b1, 30, -1, 1'b0, 1'b0};
        plan[8]  = '{2,  1'b0, 30, -1, 1'b0, 1'b0};
        plan[9]  = '{0,  1'b1, 30, -1, 1'b0, 1'b0};
        plan[10] = '{15, 1'b1, 30, -1, 1'b0, 1'b0};
        plan[11] = '{9,  1'b0, 30, -1, 1'b0, 1'b0};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset setting of one channel, no reference.
        // The store reads as zero after reset.
        send_request(read_request(3'd0));
        send_request(read_request(3'd7));
        // A full scan cycle: busy is ignored outside the wait phase, and the
        // sequencer holds in the wait phase while the converter is busy. A
        // read in the middle leaves the phase alone.
        send_request(tick_request(1'b1, 10'h155));
        send_request(tick_request(1'b1, 10'h2AA));
        send_request(tick_request(1'b0, 10'h000));
        send_request(tick_request(1'b1, 10'h3FF));
        send_request(read_request(3'd3));
        send_request(tick_request(1'b1, 10'h000));
        send_request(tick_request(1'b0, 10'h3FF));
        send_request(read_request(3'd0));
        // The lowest result overwrites the highest one.
        send_request(tick_request(1'b0, 10'h3FF));
        send_request(tick_request(1'b0, 10'h3FF));
        send_request(tick_request(1'b0, 10'h3FF));
        send_request(tick_request(1'b0, 10'h000));
        send_request(read_request(3'd0));
        // Only bits 9..2 are kept.
        send_request(tick_request(1'b0, 10'h000));
        send_request(tick_request(1'b0, 10'h000));
        send_request(tick_request(1'b0, 10'h000));
        send_request(tick_request(1'b0, 10'h203));
        send_request(read_request(3'd0));

        for (int p = 0; p < 12; p++) begin
            // Registers change only with nothing in flight.
            wait_drained();
            apb_write(REG_CHANNEL_COUNT, plan[p].count);
            apb_write(REG_REFERENCE, {31'd0, plan[p].ref_on});
            calm <= plan[p].quiet;

            // Mostly ticks, so the scan keeps moving through every phase;
            // about a fifth of the requests read the store at random.
            for (int n = 0; n < plan[p].items; n++) begin
                if (plan[p].drain_mid && n == plan[p].items / 2) begin
                    wait_drained();
                end
                req.op                = ($urandom_range(99) < 20) ? OP_READ : OP_TICK;
                req.converter_busy    = ($urandom_range(99) < 35);
                req.conversion_result = ConvW'($urandom);
                req.read_index        = IdxW'($urandom);
                send_request(req);
            end

            if (plan[p].land >= 0) begin
                while (!(sb.phase == PH_SELECT && int'(sb.scan_index) == plan[p].land)) begin
                    send_request(tick_request(1'b0, ConvW'($urandom)));
                end
            end
        end

        calm <= 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
